// ===== rtl/keyed_fnv1a_fmix_hash_top_defines.svh =====
// Assertion macros for the keyed FNV-1a / fmix32 hash block.
// Included by keyed_fnv1a_fmix_hash_top; relies on signals clk and rst_n in scope.
`ifndef KEYED_FNV1A_FMIX_HASH_TOP_DEFINES_SVH
`define KEYED_FNV1A_FMIX_HASH_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define KFH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kfh assertion failed");

// Next-cycle implication, checked out of reset
`define KFH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kfh assertion failed");

`endif

// ===== rtl/kfh_pkg.sv =====
// Shared constants, types and helpers for the keyed FNV-1a / fmix32 hash block.
// No dependencies; used by kfh_mul and keyed_fnv1a_fmix_hash_top.
package kfh_pkg;

    localparam int unsigned HashWidth = 32;
    localparam int unsigned ByteWidth = 8;

    localparam logic [HashWidth-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HashWidth-1:0] FNV_PRIME = 32'd16777619;
    localparam logic [HashWidth-1:0] MIX_C1    = 32'h85EB_CA6B;
    localparam logic [HashWidth-1:0] MIX_C2    = 32'hC2B2_AE35;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_POST
    } state_t;

    // Which multiply of the item is in flight
    typedef enum logic [1:0] {
        PH_ABSORB,
        PH_MIX1,
        PH_MIX2
    } mix_phase_t;

    // Control from the sequencer to the shared multiplier
    typedef struct packed {
        logic       load;
        mix_phase_t phase;
    } mul_ctrl_t;

    // Constant multiplier for each phase
    function automatic logic [HashWidth-1:0] mix_const(input mix_phase_t phase);
        logic [HashWidth-1:0] c;
        begin
            case (phase)
                PH_ABSORB: c = FNV_PRIME;
                PH_MIX1:   c = MIX_C1;
                PH_MIX2:   c = MIX_C2;
                default:   c = FNV_PRIME;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== rtl/kfh_mul.sv =====
// Shared 32x32 multiplier (low 32 bits) with a registered product.
// Depends on kfh_pkg for the phase constants and the control struct.
module kfh_mul
    import kfh_pkg::*;
(
    input  logic                 clk,
    input  mul_ctrl_t            ctrl,
    input  logic [HashWidth-1:0] operand,
    output logic [HashWidth-1:0] product
);

    logic [HashWidth-1:0] prod_reg;
    logic [HashWidth-1:0] prod_next;

    // Multiply by the constant of the current phase, keep the low word
    always_comb
    begin
        prod_next = operand * mix_const(ctrl.phase);
    end

    // Capture the product when the sequencer fires the unit
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign product = prod_reg;

endmodule

// ===== rtl/keyed_fnv1a_fmix_hash_top.sv =====
// Top level of the keyed FNV-1a hash with murmur3 fmix32 finalizer.
// Depends on kfh_pkg, kfh_mul and keyed_fnv1a_fmix_hash_top_defines.svh.
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------------------
//  in      | in_valid / in_stall (out)  | first_item, salt, has_byte, data_byte,
//          |                            | last_item
//  out     | out_valid / out_stall (in) | hash_value
//  cfg     | cfg_valid / cfg_ready      | cfg_data (hash_key)
//
// One shared multiplier; each multiply is fired in ST_MUL and its product used in ST_POST.
// Item with a byte and no last mark: accepted, one absorb multiply, then ready again.
// Last item: 3 multiplies with a byte (absorb, mix1, mix2) or 2 without (mix1, mix2),
// then the hash sits in the output register. An item with neither byte nor last stays idle.
// A stalled output holds the sequencer at its final step until the register frees.
// Reset clears the key, the running value and all control state.
module keyed_fnv1a_fmix_hash_top
    import kfh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [HashWidth-1:0] cfg_data,
    // input items
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 first_item,
    input  logic [ByteWidth-1:0] salt,
    input  logic                 has_byte,
    input  logic [ByteWidth-1:0] data_byte,
    input  logic                 last_item,
    // result items
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [HashWidth-1:0] hash_value
);

`include "keyed_fnv1a_fmix_hash_top_defines.svh"

    state_t               state_reg,     state_next;
    mix_phase_t           phase_reg,     phase_next;
    logic                 last_reg,      last_next;
    logic                 out_valid_reg, out_valid_next;
    logic [HashWidth-1:0] key_reg;
    logic [HashWidth-1:0] running_reg,   running_next;
    logic [HashWidth-1:0] work_reg,      work_next;
    logic [HashWidth-1:0] hash_reg,      hash_next;

    logic                 in_accept;
    logic                 out_free;
    logic [HashWidth-1:0] seeded;
    logic [HashWidth-1:0] product;
    mul_ctrl_t            mul_ctrl;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Seed from basis, key and salt on a first item, else carry on
    assign seeded = first_item
        ? (FNV_BASIS ^ key_reg ^ {{(HashWidth-ByteWidth){1'b0}}, salt})
        : running_reg;

    // Shared multiplier
    kfh_mul u_mul (
        .clk     (clk),
        .ctrl    (mul_ctrl),
        .operand (work_reg),
        .product (product)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (has_byte || last_item))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_POST;
            end
            ST_POST:
            begin
                case (phase_reg)
                    PH_ABSORB: state_next = last_reg ? ST_MUL : ST_IDLE;
                    PH_MIX1:   state_next = ST_MUL;
                    PH_MIX2:   state_next = out_free ? ST_IDLE : ST_POST;
                    default:   state_next = ST_IDLE;
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_stall       = (state_reg != ST_IDLE);
        cfg_ready      = (state_reg == ST_IDLE);
        mul_ctrl.load  = (state_reg == ST_MUL);
        mul_ctrl.phase = phase_reg;
    end

    // Datapath updates
    always_comb
    begin
        phase_next     = phase_reg;
        last_next      = last_reg;
        running_next   = running_reg;
        work_next      = work_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    last_next    = last_item;
                    running_next = seeded;
                    if (has_byte)
                    begin
                        work_next  = seeded ^ {{(HashWidth-ByteWidth){1'b0}}, data_byte};
                        phase_next = PH_ABSORB;
                    end
                    else
                    begin
                        work_next  = seeded ^ (seeded >> 16);
                        phase_next = PH_MIX1;
                    end
                end
            end
            ST_POST:
            begin
                case (phase_reg)
                    PH_ABSORB:
                    begin
                        running_next = product;
                        work_next    = product ^ (product >> 16);
                        phase_next   = PH_MIX1;
                    end
                    PH_MIX1:
                    begin
                        work_next  = product ^ (product >> 13);
                        phase_next = PH_MIX2;
                    end
                    PH_MIX2:
                    begin
                        if (out_free)
                        begin
                            hash_next      = product ^ (product >> 16);
                            out_valid_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_ABSORB;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_ABSORB;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            running_reg   <= '0;
            key_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            running_reg   <= running_next;
            if (cfg_valid && cfg_ready)
            begin
                key_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        hash_reg <= hash_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    // A byte item goes straight to the absorb multiply
    `KFH_ASSERT_NEXT(a_byte_to_absorb, in_accept && has_byte,
                     state_reg == ST_MUL && phase_reg == PH_ABSORB)

    // An item with neither byte nor last mark leaves the block idle
    `KFH_ASSERT_NEXT(a_empty_item_idle, in_accept && !has_byte && !last_item,
                     state_reg == ST_IDLE)

    // A result appears only after the second finalizer multiply
    `KFH_ASSERT_NOW(a_result_after_mix2, $rose(out_valid_reg),
                    $past(state_reg) == ST_POST && $past(phase_reg) == PH_MIX2)

endmodule
